FILE: hw/rtl/crcfd_pkg.sv
// Shared types, constants and the CRC-32C byte update for the frame decoder.
`default_nettype none

package crcfd_pkg;

  // Header layout: byte offsets of the big-endian fields
  localparam logic [3:0] HdrCrcAt  = 4'd4;
  localparam logic [3:0] HdrVerAt  = 4'd8;
  localparam logic [3:0] HdrTypeAt = 4'd10;
  localparam logic [3:0] HdrLenAt  = 4'd12;
  localparam logic [3:0] HdrLast   = 4'd15;

  // CRC-32C, reflected form
  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcSeed = 32'hFFFF_FFFF;

  // Configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgMagic   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgVersion = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgTypeCnt = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxPay  = 8'd3;
  localparam logic [31:0] MaxPayloadReset = 32'd65536;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MAGIC     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_TYPE      = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_CRC       = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SKIP    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] type_count;
    logic [31:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [15:0] msg_type;
    logic [31:0] payload_length;
    logic        last;
  } item_t;

  // One byte of CRC-32C, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crc_checked_frame_decoder_unit.sv
// Top level of the CRC-32C checked frame decoder: config registers, front, queue, back.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, rx_byte_i, buffer_end_i | request in
//   out     | out_valid_o/out_ready_i, item_kind_o,          | request out
//           | payload_byte_o, status_o, msg_type_o,          |
//           | payload_length_o, frame_last_o                 |
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i                | write only
//
// One byte is taken per cycle; header decode, checks and the CRC-32C byte
// update all finish in the accepting cycle. A result is written into the
// queue and loaded from there into the output register when it is empty or being drained.
// The queue holds QueueDepth requests; input stalls only when it is full.
// Reset clears the frame state and loads max_payload with 65536, the rest 0.
`default_nettype none

module crc_checked_frame_decoder_unit #(
  parameter int unsigned QueueDepth = crcfd_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [crcfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crcfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic                          buffer_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               item_kind_o,
  output logic [7:0]                         payload_byte_o,
  output logic [2:0]                         status_o,
  output logic [15:0]                        msg_type_o,
  output logic [31:0]                        payload_length_o,
  output logic                               frame_last_o
);

  crcfd_pkg::cfg_t  cfg_q;
  logic             push, full, q_valid, q_pop;
  crcfd_pkg::item_t push_item, q_head, out_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic       <= '0;
      cfg_q.version     <= '0;
      cfg_q.type_count  <= '0;
      cfg_q.max_payload <= crcfd_pkg::MaxPayloadReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crcfd_pkg::CfgMagic:   cfg_q.magic       <= cfg_data_i;
        crcfd_pkg::CfgVersion: cfg_q.version     <= cfg_data_i[15:0];
        crcfd_pkg::CfgTypeCnt: cfg_q.type_count  <= cfg_data_i[15:0];
        crcfd_pkg::CfgMaxPay:  cfg_q.max_payload <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crcfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .buffer_end_i (buffer_end_i),
    .full_i       (full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  crcfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  crcfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  // Spread the output request onto its ports
  assign item_kind_o      = out_item.kind;
  assign payload_byte_o   = out_item.payload_byte;
  assign status_o         = out_item.status;
  assign msg_type_o       = out_item.msg_type;
  assign payload_length_o = out_item.payload_length;
  assign frame_last_o     = out_item.last;

endmodule

`default_nettype wire

FILE: hw/rtl/crcfd_front.sv
// Front part: takes received bytes, decodes and checks the header, runs the CRC.
`default_nettype none

module crcfd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire crcfd_pkg::cfg_t cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            buffer_end_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output crcfd_pkg::item_t     push_item_o
);

  crcfd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_idx_q;
  logic [31:0] crc_q;
  logic [31:0] magic_q;
  logic [31:0] rcrc_q;
  logic [15:0] ver_q;
  logic [15:0] type_q;
  logic [31:0] len_q;
  logic [31:0] remain_q;

  logic              accept;
  logic              hdr_final;
  logic              in_crc_field;
  logic [31:0]       len_n;
  logic [31:0]       crc_n;
  logic              crc_ok;
  crcfd_pkg::status_e hdr_st;
  crcfd_pkg::status_e crc_st;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hdr_final  = (hdr_idx_q == crcfd_pkg::HdrLast);
  assign len_n      = {len_q[23:0], rx_byte_i};

  // CRC update, with the CRC field of the header taken as zeros
  always_comb begin
    in_crc_field = (hdr_idx_q >= crcfd_pkg::HdrCrcAt) && (hdr_idx_q < crcfd_pkg::HdrVerAt)
                   && (phase_q == crcfd_pkg::PH_HEADER);
    crc_n  = crcfd_pkg::crc_byte(crc_q, in_crc_field ? 8'd0 : rx_byte_i);
    crc_ok = ((crc_n ^ crcfd_pkg::CrcSeed) == rcrc_q);
    crc_st = crc_ok ? crcfd_pkg::ST_OK : crcfd_pkg::ST_CRC;
  end

  // Header checks in priority order
  always_comb begin
    if (magic_q != cfg_i.magic) begin
      hdr_st = crcfd_pkg::ST_MAGIC;
    end else if (ver_q != cfg_i.version) begin
      hdr_st = crcfd_pkg::ST_VERSION;
    end else if (type_q >= cfg_i.type_count) begin
      hdr_st = crcfd_pkg::ST_TYPE;
    end else if (len_n > cfg_i.max_payload) begin
      hdr_st = crcfd_pkg::ST_TOO_LONG;
    end else begin
      hdr_st = crcfd_pkg::ST_OK;
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      case (phase_q)
        crcfd_pkg::PH_HEADER: begin
          if (hdr_final) begin
            if (hdr_st != crcfd_pkg::ST_OK || len_n == 32'd0) begin
              phase_d = crcfd_pkg::PH_SKIP;
            end else begin
              phase_d = crcfd_pkg::PH_PAYLOAD;
            end
          end
        end
        crcfd_pkg::PH_PAYLOAD: begin
          if (remain_q == 32'd1) begin
            phase_d = crcfd_pkg::PH_SKIP;
          end
        end
        default: phase_d = phase_q;
      endcase
      if (buffer_end_i) begin
        phase_d = crcfd_pkg::PH_HEADER;
      end
    end
  end

  // Result request for the queue
  always_comb begin
    push_o                     = 1'b0;
    push_item_o.kind           = crcfd_pkg::KindStatus;
    push_item_o.payload_byte   = 8'd0;
    push_item_o.status         = crcfd_pkg::ST_OK;
    push_item_o.msg_type       = type_q;
    push_item_o.payload_length = len_q;
    push_item_o.last           = 1'b1;
    case (phase_q)
      crcfd_pkg::PH_HEADER: begin
        if (hdr_final) begin
          push_item_o.payload_length = len_n;
          if (hdr_st != crcfd_pkg::ST_OK) begin
            push_o             = accept;
            push_item_o.status = hdr_st;
          end else if (len_n == 32'd0) begin
            push_o             = accept;
            push_item_o.status = crc_st;
          end else begin
            push_o             = accept && buffer_end_i;
            push_item_o.status = crcfd_pkg::ST_TRUNCATED;
          end
        end else begin
          push_o                     = accept && buffer_end_i;
          push_item_o.status         = crcfd_pkg::ST_TRUNCATED;
          push_item_o.msg_type       = 16'd0;
          push_item_o.payload_length = 32'd0;
        end
      end
      crcfd_pkg::PH_PAYLOAD: begin
        push_o                   = accept;
        push_item_o.payload_byte = rx_byte_i;
        if (remain_q == 32'd1) begin
          push_item_o.status = crc_st;
        end else if (buffer_end_i) begin
          push_item_o.status = crcfd_pkg::ST_TRUNCATED;
        end else begin
          push_item_o.kind = crcfd_pkg::KindPayload;
          push_item_o.last = 1'b0;
        end
      end
      default: push_o = 1'b0;
    endcase
  end

  // Control state: phase, header byte index, running CRC
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= crcfd_pkg::PH_HEADER;
      hdr_idx_q <= 4'd0;
      crc_q     <= crcfd_pkg::CrcSeed;
    end else begin
      phase_q <= phase_d;
      if (accept) begin
        if (buffer_end_i) begin
          hdr_idx_q <= 4'd0;
          crc_q     <= crcfd_pkg::CrcSeed;
        end else if (phase_q == crcfd_pkg::PH_HEADER) begin
          hdr_idx_q <= hdr_idx_q + 4'd1;
          crc_q     <= crc_n;
        end else if (phase_q == crcfd_pkg::PH_PAYLOAD) begin
          crc_q <= crc_n;
        end
      end
    end
  end

  // Header fields shift in; each is fully overwritten before it is read
  always_ff @(posedge clk_i) begin
    if (accept && phase_q == crcfd_pkg::PH_HEADER) begin
      if (hdr_idx_q < crcfd_pkg::HdrCrcAt) begin
        magic_q <= {magic_q[23:0], rx_byte_i};
      end else if (hdr_idx_q < crcfd_pkg::HdrVerAt) begin
        rcrc_q <= {rcrc_q[23:0], rx_byte_i};
      end else if (hdr_idx_q < crcfd_pkg::HdrTypeAt) begin
        ver_q <= {ver_q[7:0], rx_byte_i};
      end else if (hdr_idx_q < crcfd_pkg::HdrLenAt) begin
        type_q <= {type_q[7:0], rx_byte_i};
      end else begin
        len_q <= len_n;
      end
      if (hdr_final) begin
        remain_q <= len_n;
      end
    end else if (accept && phase_q == crcfd_pkg::PH_PAYLOAD) begin
      remain_q <= remain_q - 32'd1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crcfd_queue.sv
// Short request queue between the front and back parts.
`default_nettype none

module crcfd_queue #(
  parameter int unsigned Depth = crcfd_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire crcfd_pkg::item_t push_item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output crcfd_pkg::item_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  crcfd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == Full);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crcfd_back.sv
// Back part: takes requests from the queue and presents them in the output register.
`default_nettype none

module crcfd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire crcfd_pkg::item_t q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output crcfd_pkg::item_t      out_item_o
);

  logic             out_valid_q, out_valid_d;
  crcfd_pkg::item_t out_item_q;

  // Load when the register is empty or being drained
  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = q_pop_o || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= q_head_i;
    end
  end

endmodule

`default_nettype wire
